// ===== rtl/stereo_delay_line_pitch_shifter_macros.svh =====
// ----------------------------------------------------------------------------
// stereo delay line pitch shifter assertion macros
// clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef STEREO_DELAY_LINE_PITCH_SHIFTER_MACROS_SVH
`define STEREO_DELAY_LINE_PITCH_SHIFTER_MACROS_SVH

// property must hold at every clock edge out of reset
`define SDLPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true out of reset
`define SDLPS_NEVER(lbl, expr, msg) \
  `SDLPS_ASSERT(lbl, !(expr), msg)

`endif

// ===== rtl/sdlps_pkg.sv =====
// ----------------------------------------------------------------------------
// sdlps_pkg
// shared constants, types and the lane control struct of the pitch shifter
// ----------------------------------------------------------------------------
`default_nettype none

package sdlps_pkg;

  localparam int STORE_DEPTH = 720;
  localparam int HALF_DEPTH  = STORE_DEPTH / 2;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int WT_W        = $clog2(HALF_DEPTH + 1);
  localparam int SAMPLE_W    = 16;
  localparam int PROD_W      = SAMPLE_W + WT_W + 1;
  localparam int ABS_W       = PROD_W - 2;
  localparam int QUO_W       = SAMPLE_W + 1;
  localparam int N_STAGES    = 5;
  localparam int CFG_IDX_W   = 2;

  // floor(2^ABS_W / HALF_DEPTH): quotient estimate is low by at most one
  localparam logic [ABS_W-1:0] RECIP = ABS_W'((64'd1 << ABS_W) / HALF_DEPTH);

  localparam logic [CFG_IDX_W-1:0] CFG_BYPASS     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_DOWN = CFG_IDX_W'(1);

  typedef logic [ADDR_W-1:0]          addr_t;
  typedef logic [WT_W-1:0]            weight_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic [N_STAGES-1:0] en;     // load enable per pipeline stage
    logic                we;     // store write this cycle
    logic                clr;    // write zero (clearing pass)
    addr_t               waddr;
    addr_t               ra_a;
    addr_t               ra_b;
    weight_t             w_a;
    weight_t             w_b;
    logic                byp;
  } sdlps_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/sdlps_ctrl.sv =====
// ----------------------------------------------------------------------------
// sdlps_ctrl
// write position, sweep delay, tap addresses, crossfade weights, config
// registers, store clearing pass and the stage handshake of the lanes
// ----------------------------------------------------------------------------
`default_nettype none
`include "stereo_delay_line_pitch_shifter_macros.svh"

module sdlps_ctrl
  import sdlps_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 out_free,
  output logic                      last_valid,
  input  wire logic                 cfg_valid,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic                 cfg_data,
  output sdlps_ctl_t                ctl
);

  localparam logic [ADDR_W:0] DEPTH_X   = (ADDR_W + 1)'(STORE_DEPTH);
  localparam logic [ADDR_W:0] HALF_X    = (ADDR_W + 1)'(HALF_DEPTH);
  localparam addr_t           LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);
  localparam addr_t           HALF_ADDR = ADDR_W'(HALF_DEPTH);

  addr_t               wp_r, wp_nxt;
  addr_t               d_r, d_nxt;
  addr_t               clr_cnt_r, clr_cnt_nxt;
  logic                clr_r, clr_nxt;
  logic                byp_r, byp_nxt;
  logic                pd_r, pd_nxt;
  logic [N_STAGES-1:0] v_r, v_nxt;
  logic [N_STAGES-1:0] free;
  logic                accept;

  logic [ADDR_W:0] sum_up, dif_dn, ia_x, ib_x;
  addr_t           ia, ib, m;

  // stage k is free when empty or when its item moves on this cycle
  always_comb begin
    free[N_STAGES-1] = !v_r[N_STAGES-1] || out_free;
    for (int k = N_STAGES - 2; k >= 0; k--) begin
      free[k] = !v_r[k] || free[k+1];
    end
  end

  assign in_ready   = free[0] && !clr_r;
  assign accept     = in_valid && in_ready;
  assign last_valid = v_r[N_STAGES-1];

  always_comb begin
    v_nxt[0] = free[0] ? accept : v_r[0];
    for (int k = 1; k < N_STAGES; k++) begin
      v_nxt[k] = free[k] ? v_r[k-1] : v_r[k];
    end
  end

  // tap addresses, both wrapped with one compare and subtract
  always_comb begin
    sum_up = {1'b0, wp_r} + {1'b0, d_r};
    dif_dn = {1'b0, wp_r} + DEPTH_X - {1'b0, d_r};
    if (pd_r) begin
      ia_x = (dif_dn >= DEPTH_X) ? dif_dn - DEPTH_X : dif_dn;
    end else begin
      ia_x = (sum_up >= DEPTH_X) ? sum_up - DEPTH_X : sum_up;
    end
    ia   = ia_x[ADDR_W-1:0];
    ib_x = {1'b0, ia} + HALF_X;
    ib   = (ib_x >= DEPTH_X) ? ADDR_W'(ib_x - DEPTH_X) : ib_x[ADDR_W-1:0];
    m    = (d_r >= HALF_ADDR) ? d_r - HALF_ADDR : HALF_ADDR - d_r;
  end

  always_comb begin
    ctl.en    = free;
    ctl.we    = clr_r || accept;
    ctl.clr   = clr_r;
    ctl.waddr = clr_r ? clr_cnt_r : wp_r;
    ctl.ra_a  = ia;
    ctl.ra_b  = ib;
    ctl.byp   = byp_r;
    // bypass becomes a full weight on the incoming sample
    ctl.w_a   = byp_r ? WT_W'(HALF_DEPTH) : WT_W'(HALF_DEPTH) - WT_W'(m);
    ctl.w_b   = byp_r ? '0 : WT_W'(m);
  end

  always_comb begin
    wp_nxt      = wp_r;
    d_nxt       = d_r;
    clr_nxt     = clr_r;
    clr_cnt_nxt = clr_cnt_r;
    byp_nxt     = byp_r;
    pd_nxt      = pd_r;
    if (accept) begin
      wp_nxt = (wp_r == LAST_ADDR) ? '0 : wp_r + 1'b1;
      if (!wp_r[0]) begin
        d_nxt = (d_r == LAST_ADDR) ? '0 : d_r + 1'b1;
      end
    end
    if (clr_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (clr_cnt_r == LAST_ADDR) begin
        clr_nxt = 1'b0;
      end
    end
    if (cfg_valid) begin
      case (cfg_index)
        CFG_BYPASS:     byp_nxt = cfg_data;
        CFG_PITCH_DOWN: pd_nxt  = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r      <= '0;
      d_r       <= '0;
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
      byp_r     <= 1'b0;
      pd_r      <= 1'b0;
      v_r       <= '0;
    end else begin
      wp_r      <= wp_nxt;
      d_r       <= d_nxt;
      clr_r     <= clr_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      byp_r     <= byp_nxt;
      pd_r      <= pd_nxt;
      v_r       <= v_nxt;
    end
  end

  `SDLPS_ASSERT(a_wp_step, accept |=> (wp_r == (($past(wp_r) == LAST_ADDR) ? '0 : $past(wp_r) + 1'b1)), "write position did not step by one")
  `SDLPS_ASSERT(a_sweep_hold, (accept && wp_r[0]) |=> (d_r == $past(d_r)), "sweep moved on odd position")
  `SDLPS_ASSERT(a_taps_range, (ctl.ra_a < DEPTH_X[ADDR_W-1:0] || DEPTH_X[ADDR_W]) && (ctl.ra_b < DEPTH_X[ADDR_W-1:0] || DEPTH_X[ADDR_W]), "tap address outside store")
  `SDLPS_ASSERT(a_clr_len, $fell(clr_r) |-> ($past(clr_cnt_r) == LAST_ADDR), "clearing pass ended early")
  `SDLPS_NEVER(a_no_item_in_clear, clr_r && (accept || v_r != '0), "item in flight during clearing pass")

endmodule

`default_nettype wire

// ===== rtl/sdlps_lane.sv =====
// ----------------------------------------------------------------------------
// sdlps_lane
// one channel: circular sample store, two tap reads, weighted crossfade and
// truncating division by the half depth through a reciprocal multiply
// ----------------------------------------------------------------------------
`default_nettype none

module sdlps_lane
  import sdlps_pkg::*;
(
  input  wire logic       clk,
  input  wire sdlps_ctl_t ctl,
  input  wire sample_t    x,
  output sample_t         y
);

  logic [SAMPLE_W-1:0] mem [STORE_DEPTH];

  // stage 1: tap reads and item context
  sample_t rda_r, rdb_r, x_r;
  weight_t wa_r, wb_r;
  logic    byp_r;
  // stage 2: weighted taps
  logic signed [PROD_W-1:0] pa_r, pb_r;
  // stage 3: magnitude and sign of the sum
  logic [ABS_W-1:0] abs3_r;
  logic             neg3_r;
  // stage 4: quotient estimate
  logic [QUO_W-1:0] q0_r;
  logic [ABS_W-1:0] abs4_r;
  logic             neg4_r;
  // stage 5: result
  sample_t y_r;

  logic signed [PROD_W-1:0] sum;
  logic [PROD_W-1:0]        mag;
  logic [2*ABS_W-1:0]       prod;
  logic [ABS_W-1:0]         qh, rem;
  logic [QUO_W-1:0]         q;
  logic [QUO_W-1:0]         q_sgn;
  sample_t                  tap_a;

  // read before write: taps see the store as it was before this sample
  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.waddr] <= ctl.clr ? '0 : x;
    end
    if (ctl.en[0]) begin
      rda_r <= mem[ctl.ra_a];
      rdb_r <= mem[ctl.ra_b];
    end
  end

  assign tap_a = byp_r ? x_r : rda_r;
  assign sum   = pa_r + pb_r;
  assign mag   = sum[PROD_W-1] ? -sum : sum;
  assign prod  = (2*ABS_W)'(abs3_r) * (2*ABS_W)'(RECIP);
  assign qh    = ABS_W'(q0_r * ABS_W'(HALF_DEPTH));
  assign rem   = abs4_r - qh;
  assign q     = (rem >= ABS_W'(HALF_DEPTH)) ? q0_r + 1'b1 : q0_r;
  assign q_sgn = neg4_r ? -q : q;

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      x_r   <= x;
      wa_r  <= ctl.w_a;
      wb_r  <= ctl.w_b;
      byp_r <= ctl.byp;
    end
    if (ctl.en[1]) begin
      pa_r <= $signed({1'b0, wa_r}) * tap_a;
      pb_r <= $signed({1'b0, wb_r}) * rdb_r;
    end
    if (ctl.en[2]) begin
      abs3_r <= mag[ABS_W-1:0];
      neg3_r <= sum[PROD_W-1];
    end
    if (ctl.en[3]) begin
      q0_r   <= prod[ABS_W +: QUO_W];
      abs4_r <= abs3_r;
      neg4_r <= neg3_r;
    end
    if (ctl.en[4]) begin
      y_r <= q_sgn[SAMPLE_W-1:0];
    end
  end

  assign y = y_r;

endmodule

`default_nettype wire

// ===== rtl/stereo_delay_line_pitch_shifter.sv =====
// ----------------------------------------------------------------------------
// stereo_delay_line_pitch_shifter
// two-tap crossfaded delay line pitch shifter for stereo 16-bit samples
// ----------------------------------------------------------------------------
// Takes one stereo transaction per clock while the output is not stalled and
// no clearing pass runs, and returns each one through five lane stages and
// the output register; the rate is set by the single write port and two
// read ports of each channel's 720-entry store, all used in the cycle of
// acceptance. After reset a clearing pass zeroes all 720 entries of the
// stores with in_tready low; configuration writes are taken at any time and
// must only be issued while no transaction is in flight.
`default_nettype none

module stereo_delay_line_pitch_shifter
  import sdlps_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [31:0]          in_tdata,   // left_in[15:0], right_in[31:16]
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [31:0]               out_tdata,  // left_out[15:0], right_out[31:16]
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic                 cfg_data
);

  sdlps_ctl_t ctl;
  logic       out_free;
  logic       last_valid;
  sample_t    y_left, y_right;
  logic       out_valid_r, out_valid_nxt;
  logic [31:0] out_data_r;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;

  sdlps_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .out_free   (out_free),
    .last_valid (last_valid),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .ctl        (ctl)
  );

  sdlps_lane u_lane_left (
    .clk (clk),
    .ctl (ctl),
    .x   (in_tdata[15:0]),
    .y   (y_left)
  );

  sdlps_lane u_lane_right (
    .clk (clk),
    .ctl (ctl),
    .x   (in_tdata[31:16]),
    .y   (y_right)
  );

  // merge the lanes into the output register
  assign out_valid_nxt = out_free ? last_valid : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r <= {y_right, y_left};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire
